FILE: design/bcc_pkg.sv
// Shared types and constants for the button click classifier.
package bcc_pkg;

    // Width of the configuration registers and of the APB data bus.
    localparam int CFG_WIDTH = 16;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 3;

    // Default width of the hold and gap tick counters.
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Register reset values.
    localparam logic [CFG_WIDTH-1:0] LONG_THRESHOLD_RESET = 16'd5500;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_WINDOW_RESET = 16'd2400;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_LONG_THRESHOLD = 1'b0;
    localparam logic REG_DOUBLE_WINDOW = 1'b1;

    // Input item kinds.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } click_event_t;

    // One item handed to the rule engine.
    typedef struct packed {
        logic fire;
        logic req_type;
        logic key_down;
    } bcc_step_t;

endpackage

FILE: design/bcc_rules.sv
// Press rules: press state flags, saturating tick counters and event decode.
module bcc_rules #(
    parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bcc_pkg::bcc_step_t             step,
    input  logic [bcc_pkg::CFG_WIDTH-1:0]  long_threshold,
    input  logic [bcc_pkg::CFG_WIDTH-1:0]  double_window,
    output bcc_pkg::click_event_t          click_event
);
    import bcc_pkg::*;

    localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    logic                   press_armed_reg, press_armed_next;
    logic                   gap_waiting_reg, gap_waiting_next;
    logic                   long_latched_reg, long_latched_next;
    logic [COUNT_WIDTH-1:0] hold_ticks_reg, hold_ticks_next;
    logic [COUNT_WIDTH-1:0] gap_ticks_reg, gap_ticks_next;

    logic [CMP_WIDTH-1:0] hold_cmp;
    logic [CMP_WIDTH-1:0] gap_cmp;
    logic [CMP_WIDTH-1:0] thr_cmp;
    logic [CMP_WIDTH-1:0] win_cmp;
    logic                 hold_reached;
    logic                 gap_inside;
    logic                 gap_past;

    assign hold_cmp     = CMP_WIDTH'(hold_ticks_reg);
    assign gap_cmp      = CMP_WIDTH'(gap_ticks_reg);
    assign thr_cmp      = CMP_WIDTH'(long_threshold);
    assign win_cmp      = CMP_WIDTH'(double_window);
    assign hold_reached = (hold_cmp >= thr_cmp);
    assign gap_inside   = (gap_cmp < win_cmp);
    assign gap_past     = (gap_cmp > win_cmp);

    always_comb
    begin
        press_armed_next  = press_armed_reg;
        gap_waiting_next  = gap_waiting_reg;
        long_latched_next = long_latched_reg;
        hold_ticks_next   = hold_ticks_reg;
        gap_ticks_next    = gap_ticks_reg;
        click_event       = EV_NONE;

        if (step.fire)
        begin
            if (step.req_type == REQ_TICK)
            begin
                // Both counters stop at all ones instead of wrapping.
                hold_ticks_next = (&hold_ticks_reg) ? hold_ticks_reg
                                                    : hold_ticks_reg + COUNT_WIDTH'(1);
                gap_ticks_next  = (&gap_ticks_reg) ? gap_ticks_reg
                                                   : gap_ticks_reg + COUNT_WIDTH'(1);
            end
            else if (step.key_down)
            begin
                if (!press_armed_reg)
                begin
                    press_armed_next = 1'b1;
                    hold_ticks_next  = '0;
                end
                else if (hold_reached)
                begin
                    long_latched_next = 1'b1;
                    press_armed_next  = 1'b0;
                    click_event       = EV_LONG;
                end
            end
            else
            begin
                if (press_armed_reg)
                begin
                    press_armed_next = 1'b0;
                    if (!gap_waiting_reg)
                    begin
                        gap_waiting_next = 1'b1;
                        gap_ticks_next   = '0;
                    end
                    else if (gap_inside)
                    begin
                        gap_waiting_next = 1'b0;
                        click_event      = EV_DOUBLE;
                    end
                end
                else if (gap_waiting_reg && gap_past)
                begin
                    // The wait ends by timeout; a pending long press swallows it.
                    gap_waiting_next = 1'b0;
                    if (long_latched_reg)
                    begin
                        long_latched_next = 1'b0;
                    end
                    else
                    begin
                        click_event = EV_SHORT;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_armed_reg  <= 1'b0;
            gap_waiting_reg  <= 1'b0;
            long_latched_reg <= 1'b0;
            hold_ticks_reg   <= '0;
            gap_ticks_reg    <= '0;
        end
        else
        begin
            press_armed_reg  <= press_armed_next;
            gap_waiting_reg  <= gap_waiting_next;
            long_latched_reg <= long_latched_next;
            hold_ticks_reg   <= hold_ticks_next;
            gap_ticks_reg    <= gap_ticks_next;
        end
    end

endmodule

FILE: design/button_click_classifier_unit.sv
// Top level of the button click classifier: handshake stages and APB registers.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_ready    req_type, key_down
//   output    out        out_valid / out_ready  click_event
//   config    in         APB psel / penable     paddr, pwdata, prdata
//
// Every input beat produces exactly one output beat. When the output side does
// not stall, an accepted beat passes through the input register and then the
// output register before it is presented. The block takes one beat per cycle
// while the output side does not stall; the rule engine updates its flags and
// counters as the beat moves from the input register into the output register.
// Reset is asynchronous and active low. It clears the press flags and counters
// and loads the registers with 5500 hold ticks and 2400 gap ticks.
// When out_ready is low, the output beat holds and the input register still
// accepts one more beat before in_ready drops.
module button_click_classifier_unit #(
    parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic                                key_down,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          click_event,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bcc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [bcc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [bcc_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready
);
    import bcc_pkg::*;

    // Configuration registers. Each register sits at a word address; the
    // word address bit of paddr selects it and the byte offset is ignored.
    logic [CFG_WIDTH-1:0] long_threshold_reg;
    logic [CFG_WIDTH-1:0] double_window_reg;
    logic                 cfg_write;
    logic                 reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_threshold_reg <= LONG_THRESHOLD_RESET;
            double_window_reg  <= DOUBLE_WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_LONG_THRESHOLD: long_threshold_reg <= pwdata[CFG_WIDTH-1:0];
                REG_DOUBLE_WINDOW:  double_window_reg  <= pwdata[CFG_WIDTH-1:0];
                default:            long_threshold_reg <= long_threshold_reg;
            endcase
        end
    end

    // Read data follows the address; the upper bits read as zero.
    always_comb
    begin
        unique case (reg_sel)
            REG_LONG_THRESHOLD: prdata = APB_DATA_WIDTH'(long_threshold_reg);
            REG_DOUBLE_WINDOW:  prdata = APB_DATA_WIDTH'(double_window_reg);
            default:            prdata = '0;
        endcase
    end

    // Input register. It moves forward whenever the output register is empty
    // or its beat is being taken, so a new beat can enter in every cycle.
    logic      s1_valid_reg;
    logic      s1_req_type_reg;
    logic      s1_key_down_reg;
    logic      s1_advance;
    logic      in_fire;
    bcc_step_t step;
    click_event_t step_event;

    logic         out_valid_reg;
    click_event_t out_event_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_type_reg <= req_type;
            s1_key_down_reg <= key_down;
        end
    end

    // The rule engine commits its state only when the beat moves on into the
    // output register, so a stalled beat is never applied twice.
    assign step.fire     = s1_advance;
    assign step.req_type = s1_req_type_reg;
    assign step.key_down = s1_key_down_reg;

    bcc_rules #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_rules (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .long_threshold(long_threshold_reg),
        .double_window (double_window_reg),
        .click_event   (step_event)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_event_reg <= step_event;
        end
    end

    assign out_valid   = out_valid_reg;
    assign click_event = out_event_reg;

endmodule

FILE: design/bcc_checker.sv
// Port-level checks for the button click classifier, bound to the top level.
module bcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] click_event
);
    import bcc_pkg::*;

    // A stalled output beat keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(click_event)))
        else $error("output beat changed while stalled");

    // With nothing waiting at the output the input side must be open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output is empty");

    // A long press disarms, so the very next beat cannot be long again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && click_event == EV_LONG)
        |=> !(out_valid && click_event == EV_LONG))
        else $error("two long events in consecutive beats");

    // A double closes the wait, so the very next beat cannot be double again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && click_event == EV_DOUBLE)
        |=> !(out_valid && click_event == EV_DOUBLE))
        else $error("two double events in consecutive beats");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .click_event(click_event)
);
